[rtl/software_timer_table_assert.svh]
// Assertion macros for the software timer table.
// Each macro takes a label, an antecedent, a consequent and a message.
// The clock is clk; the checks are off while rst_n is low.
`ifndef SOFTWARE_TIMER_TABLE_ASSERT_SVH
`define SOFTWARE_TIMER_TABLE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/stt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table package
// Shared constants, codes and structures of the timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Number of timer slots and the width of a slot index.
  localparam int NUM_TIMERS = 16;
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // Widths of the result fields.
  localparam int SLOT_W = 4;
  localparam int FIRE_W = 16;

  // Command codes.
  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_CREATE = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_START  = 2'd3
  } action_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic {
    S_IDLE,
    S_SWEEP
  } state_t;

  // One timer entry as stored in the table memory.
  typedef struct packed {
    logic [31:0] period;
    logic [31:0] remaining;
    logic        reload;
    logic        notify;
    logic        spent;
  } entry_t;

  // Access request from the controller to the table.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             use_we;
    logic [IDX_W-1:0] use_addr;
    logic             use_val;
  } tbl_req_t;

  // Occupancy view of the table.
  typedef struct packed {
    logic [NUM_TIMERS-1:0] used;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
  } tbl_stat_t;

  // One result item.
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [FIRE_W-1:0] fire_mask;
    logic [63:0]       tick_count;
  } result_t;

endpackage

[rtl/stt_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table storage
// Entry memory with registered read data, slot-in-use flags and the
// lowest-free-slot encoder.
// ----------------------------------------------------------------------------
module stt_table
  import stt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  tbl_req_t  req,
  output entry_t    rd_data,
  output tbl_stat_t stat
);

  entry_t                mem [NUM_TIMERS];
  entry_t                rd_data_r;
  logic [NUM_TIMERS-1:0] used_r;
  logic [NUM_TIMERS-1:0] used_nxt;
  logic                  free_found;
  logic [IDX_W-1:0]      free_idx;

  // Entry memory: one write port and one read port, read data registered.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // In-use flags; a slot whose flag is clear reads as free.
  always_comb begin
    used_nxt = used_r;
    if (req.use_we) begin
      used_nxt[req.use_addr] = req.use_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  // Lowest free slot: scan from the top so the lowest index wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign rd_data         = rd_data_r;
  assign stat.used       = used_r;
  assign stat.free_found = free_found;
  assign stat.free_idx   = free_idx;

endmodule

[rtl/stt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table controller
// Decodes commands, holds the tick gate and tick counter, and sweeps the
// table once per enabled tick, reading every slot and rewriting each in use.
// ----------------------------------------------------------------------------
module stt_ctrl
  import stt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_period,
  input  logic        in_reload,
  input  logic        in_notify,
  input  logic [3:0]  in_slot_select,
  output tbl_req_t    req,
  input  entry_t      rd_data,
  input  tbl_stat_t   stat,
  output logic        done,
  output result_t     res
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [FIRE_W-1:0] fire_r, fire_nxt;
  logic [63:0]       ticks_r, ticks_nxt;
  logic              en_r, en_nxt;
  logic [IDX_W-1:0]  sel_idx;
  logic              sel_ok;
  entry_t            upd;
  logic              fire_now;

  // Slot addressed by delete and start, and whether it holds a timer.
  assign sel_idx = IDX_W'(in_slot_select);
  assign sel_ok  = (32'(in_slot_select) < NUM_TIMERS) && stat.used[sel_idx];

  // Countdown update of the entry that the sweep has just read.
  always_comb begin
    upd      = rd_data;
    fire_now = 1'b0;
    if (upd.remaining != 32'd0) begin
      upd.remaining = upd.remaining - 32'd1;
    end
    if ((upd.remaining == 32'd0) && !upd.spent) begin
      fire_now = upd.notify;
      if (upd.reload) begin
        upd.remaining = upd.period;
      end else begin
        upd.spent = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      fire_r  <= '0;
      ticks_r <= '0;
      en_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      fire_r  <= fire_nxt;
      ticks_r <= ticks_nxt;
      en_r    <= en_nxt;
    end
  end

  // Command decode and sweep sequencing.
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    fire_nxt       = fire_r;
    ticks_nxt      = ticks_r;
    en_nxt         = en_r;
    req            = '0;
    done           = 1'b0;
    res.status     = STAT_OK;
    res.slot       = '0;
    res.fire_mask  = '0;
    res.tick_count = ticks_r;
    busy           = (state_r != S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (action_t'(in_action))
            ACT_TICK: begin
              if (en_r) begin
                // Count the tick and read slot zero to begin the sweep.
                ticks_nxt   = ticks_r + 64'd1;
                req.rd_en   = 1'b1;
                req.rd_addr = '0;
                idx_nxt     = '0;
                fire_nxt    = '0;
                state_nxt   = S_SWEEP;
              end else begin
                done = 1'b1;
              end
            end
            ACT_CREATE: begin
              done = 1'b1;
              if (in_period == 32'd0) begin
                res.status = STAT_BAD;
              end else if (!stat.free_found) begin
                res.status = STAT_FULL;
              end else begin
                req.wr_en             = 1'b1;
                req.wr_addr           = stat.free_idx;
                req.wr_data.period    = in_period;
                req.wr_data.remaining = in_period;
                req.wr_data.reload    = in_reload;
                req.wr_data.notify    = in_notify;
                req.wr_data.spent     = 1'b0;
                req.use_we            = 1'b1;
                req.use_addr          = stat.free_idx;
                req.use_val           = 1'b1;
                res.slot              = SLOT_W'(stat.free_idx);
              end
            end
            ACT_DELETE: begin
              done = 1'b1;
              if (sel_ok) begin
                req.use_we   = 1'b1;
                req.use_addr = sel_idx;
                req.use_val  = 1'b0;
              end else begin
                res.status = STAT_BAD;
              end
            end
            ACT_START: begin
              done = 1'b1;
              if (sel_ok) begin
                en_nxt = 1'b1;
              end else begin
                res.status = STAT_BAD;
              end
            end
          endcase
        end
      end
      S_SWEEP: begin
        // Write back the updated entry and note its expiry.
        if (stat.used[idx_r]) begin
          req.wr_en   = 1'b1;
          req.wr_addr = idx_r;
          req.wr_data = upd;
          if (fire_now && (32'(idx_r) < FIRE_W)) begin
            fire_nxt[4'(idx_r)] = 1'b1;
          end
        end
        if (idx_r == LAST_IDX) begin
          done          = 1'b1;
          res.fire_mask = fire_nxt;
          state_nxt     = S_IDLE;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = idx_r + IDX_W'(1);
          idx_nxt     = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/software_timer_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table
// Table of countdown timers with create, delete, start and tick commands.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                  | Transfer
//  ---------+----------------------------------------+-------------------------
//  command  | start, busy, in_*                      | start high, busy low
//  result   | out_strobe, out_*                      | out_strobe, one cycle
//
// Create, delete, start and a tick while the gate is off are answered at once;
// the result shows on the cycle after the transfer. An enabled tick reads every
// slot of the entry memory through its single read port, one slot per cycle,
// rewrites each slot in use and holds busy until the last slot is done, then
// registers its result. Reset clears the in-use flags, the tick gate and the
// tick count at once; no clearing pass is needed. The receiver cannot stall:
// each result is valid for exactly one cycle.
//
module software_timer_table
  import stt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_period,
  input  logic        in_reload,
  input  logic        in_notify,
  input  logic [3:0]  in_slot_select,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot,
  output logic [15:0] out_fire_mask,
  output logic [63:0] out_tick_count
);

`include "software_timer_table_assert.svh"

  tbl_req_t  req;
  entry_t    rd_data;
  tbl_stat_t stat;
  logic      done;
  result_t   res;
  logic      strobe_r;
  result_t   res_r;
  logic      quick_cmd;
  logic      refused_res;

  stt_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data),
    .stat    (stat)
  );

  stt_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_period      (in_period),
    .in_reload      (in_reload),
    .in_notify      (in_notify),
    .in_slot_select (in_slot_select),
    .req            (req),
    .rd_data        (rd_data),
    .stat           (stat),
    .done           (done),
    .res            (res)
  );

  // Result register: the strobe is control, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= res;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_status     = res_r.status;
  assign out_slot       = res_r.slot;
  assign out_fire_mask  = res_r.fire_mask;
  assign out_tick_count = res_r.tick_count;

  // Conditions watched by the checks below.
  assign quick_cmd   = start && !busy && (in_action != ACT_TICK);
  assign refused_res = out_strobe && (out_status != STAT_OK);

  // A command other than a tick is answered in the next cycle.
  `STT_ASSERT_NEXT(a_quick_answer, quick_cmd, out_strobe, "command result missing")
  // No result can show while a sweep is still running.
  `STT_ASSERT_NOW(a_no_result_in_sweep, busy, !out_strobe, "result during sweep")
  // A refused command never reports a slot.
  `STT_ASSERT_NOW(a_full_no_slot, refused_res, out_slot == 4'd0, "slot on failure")

endmodule

[test/software_timer_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table testbench
// Drives tick, create, delete and start commands into the timer table. A
// short directed table covers reset values, a full table, refused creates,
// bad slots and the first expiries. Several hundred random commands follow,
// sent in bursts with random gaps. Every result is checked field by field
// against the row's own result or a timer table model kept in this bench.
// ----------------------------------------------------------------------------
module software_timer_table_tb;
  import stt_pkg::*;

  // Cycles with no transfer on either channel before the run is abandoned.
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 700;

  // One row of the directed stimulus; the typed result is used when typed is set.
  typedef struct packed {
    action_t     act;
    logic [31:0] period;
    logic        reload;
    logic        notify;
    logic [3:0]  sel;
    int          reps;
    logic        typed;
    status_t     st;
    logic [3:0]  slot;
    logic [15:0] fire;
    logic [63:0] count;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = 2'd0;
  logic [31:0] in_period = 32'd0;
  logic        in_reload = 1'b0;
  logic        in_notify = 1'b0;
  logic [3:0]  in_slot_select = 4'd0;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [3:0]  out_slot;
  logic [15:0] out_fire_mask;
  logic [63:0] out_tick_count;

  // Timer table model state.
  logic [31:0] tmr_period [NUM_TIMERS];
  logic [31:0] tmr_remain [NUM_TIMERS];
  logic        tmr_reload [NUM_TIMERS];
  logic        tmr_notify [NUM_TIMERS];
  logic        tmr_spent  [NUM_TIMERS];
  logic        gate_on;
  logic [63:0] tick_total;

  result_t   pending_results [$];
  stim_row_t directed_rows [$];
  int        error_count = 0;
  int        burst_left;

  software_timer_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_period      (in_period),
    .in_reload      (in_reload),
    .in_notify      (in_notify),
    .in_slot_select (in_slot_select),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_fire_mask  (out_fire_mask),
    .out_tick_count (out_tick_count)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Reset contents of the model table.
  task automatic clear_timers();
    for (int i = 0; i < NUM_TIMERS; i++) begin
      tmr_period[i] = '0;
      tmr_remain[i] = '0;
      tmr_reload[i] = 1'b0;
      tmr_notify[i] = 1'b0;
      tmr_spent[i]  = 1'b0;
    end
    gate_on    = 1'b0;
    tick_total = '0;
  endtask

  // Apply one command to the model table and return the result it produces.
  task automatic predict_result(input action_t act, input logic [31:0] per,
                                input logic rel, input logic ntf,
                                input logic [3:0] sel, output result_t res);
    logic found;
    res.status     = STAT_OK;
    res.slot       = '0;
    res.fire_mask  = '0;
    found          = 1'b0;
    case (act)
      ACT_TICK: begin
        if (gate_on) begin
          tick_total = tick_total + 64'd1;
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (tmr_period[i] != 32'd0) begin
              if (tmr_remain[i] != 32'd0) tmr_remain[i] = tmr_remain[i] - 32'd1;
              if (tmr_remain[i] == 32'd0 && !tmr_spent[i]) begin
                if (tmr_notify[i] && i < FIRE_W) res.fire_mask[i] = 1'b1;
                if (tmr_reload[i]) tmr_remain[i] = tmr_period[i];
                else tmr_spent[i] = 1'b1;
              end
            end
          end
        end
      end
      ACT_CREATE: begin
        if (per == 32'd0) begin
          res.status = STAT_BAD;
        end else begin
          res.status = STAT_FULL;
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (!found && tmr_period[i] == 32'd0) begin
              found         = 1'b1;
              tmr_period[i] = per;
              tmr_remain[i] = per;
              tmr_reload[i] = rel;
              tmr_notify[i] = ntf;
              tmr_spent[i]  = 1'b0;
              res.status    = STAT_OK;
              res.slot      = i[SLOT_W-1:0];
            end
          end
        end
      end
      ACT_DELETE: begin
        if (int'(sel) < NUM_TIMERS && tmr_period[sel] != 32'd0) begin
          tmr_period[sel] = '0;
          tmr_remain[sel] = '0;
          tmr_reload[sel] = 1'b0;
          tmr_notify[sel] = 1'b0;
          tmr_spent[sel]  = 1'b0;
        end else begin
          res.status = STAT_BAD;
        end
      end
      default: begin
        if (int'(sel) < NUM_TIMERS && tmr_period[sel] != 32'd0) gate_on = 1'b1;
        else res.status = STAT_BAD;
      end
    endcase
    res.tick_count = tick_total;
  endtask

  // Present one command and hold it until the transfer; start stays high after.
  task automatic send_command(input action_t act, input logic [31:0] per,
                              input logic rel, input logic ntf,
                              input logic [3:0] sel, input logic typed,
                              input result_t typed_res);
    result_t res;
    start          <= 1'b1;
    in_action      <= act;
    in_period      <= per;
    in_reload      <= rel;
    in_notify      <= ntf;
    in_slot_select <= sel;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_result(act, per, rel, ntf, sel, res);
    if (typed) res = typed_res;
    pending_results.push_back(res);
  endtask

  // Sender bursts: after each burst, drop start for a random number of cycles.
  task automatic burst_gap();
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Hold off the sender until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic stim_row_t mk_row(action_t act, logic [31:0] per, logic rel,
                                       logic ntf, logic [3:0] sel, int reps,
                                       logic typed, status_t st, logic [3:0] slot,
                                       logic [15:0] fire, logic [63:0] count);
    stim_row_t row;
    row.act    = act;
    row.period = per;
    row.reload = rel;
    row.notify = ntf;
    row.sel    = sel;
    row.reps   = reps;
    row.typed  = typed;
    row.st     = st;
    row.slot   = slot;
    row.fire   = fire;
    row.count  = count;
    return row;
  endfunction

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d slot %0d fire %h count %0d",
                 $time, out_status, out_slot, out_fire_mask, out_tick_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_slot !== want.slot) begin
          $display("%0t: slot expected %0d, got %0d", $time, want.slot, out_slot);
          error_count++;
        end
        if (out_fire_mask !== want.fire_mask) begin
          $display("%0t: fire_mask expected %h, got %h", $time, want.fire_mask,
                   out_fire_mask);
          error_count++;
        end
        if (out_tick_count !== want.tick_count) begin
          $display("%0t: tick_count expected %0d, got %0d", $time, want.tick_count,
                   out_tick_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: abandon the run when neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_strobe) quiet = 0;
      else quiet++;
    end
    $display("software_timer_table_tb: errors");
    $finish;
  end

  // Stimulus: directed table, then random commands, then the final verdict.
  initial begin : stimulus
    result_t     typed_res;
    action_t     act;
    logic [31:0] per;
    int          pick;

    clear_timers();
    burst_left = $urandom_range(1, 12);

    // Reset and gate-off behavior.
    directed_rows.push_back(mk_row(ACT_TICK, 32'd0, 1'b0, 1'b0, 4'd0, 1, 1'b1,
                                   STAT_OK, 4'd0, 16'h0000, 64'd0));
    directed_rows.push_back(mk_row(ACT_CREATE, 32'd0, 1'b1, 1'b1, 4'd0, 1, 1'b1,
                                   STAT_BAD, 4'd0, 16'h0000, 64'd0));
    directed_rows.push_back(mk_row(ACT_DELETE, 32'd0, 1'b0, 1'b0, 4'd15, 1, 1'b1,
                                   STAT_BAD, 4'd0, 16'h0000, 64'd0));
    directed_rows.push_back(mk_row(ACT_START, 32'd0, 1'b0, 1'b0, 4'd3, 1, 1'b1,
                                   STAT_BAD, 4'd0, 16'h0000, 64'd0));
    directed_rows.push_back(mk_row(ACT_TICK, 32'd0, 1'b0, 1'b0, 4'd0, 1, 1'b1,
                                   STAT_OK, 4'd0, 16'h0000, 64'd0));
    // Fill the table: shortest one-shot, longest periodic, then the rest.
    directed_rows.push_back(mk_row(ACT_CREATE, 32'd1, 1'b0, 1'b1, 4'd0, 1, 1'b1,
                                   STAT_OK, 4'd0, 16'h0000, 64'd0));
    directed_rows.push_back(mk_row(ACT_CREATE, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'd0, 1,
                                   1'b1, STAT_OK, 4'd1, 16'h0000, 64'd0));
    directed_rows.push_back(mk_row(ACT_CREATE, 32'd3, 1'b1, 1'b0, 4'd0, 1, 1'b1,
                                   STAT_OK, 4'd2, 16'h0000, 64'd0));
    directed_rows.push_back(mk_row(ACT_CREATE, 32'd2, 1'b1, 1'b1, 4'd0, 13, 1'b0,
                                   STAT_OK, 4'd0, 16'h0000, 64'd0));
    directed_rows.push_back(mk_row(ACT_CREATE, 32'd5, 1'b0, 1'b0, 4'd0, 1, 1'b1,
                                   STAT_FULL, 4'd0, 16'h0000, 64'd0));
    // Open the gate, twice, then tick.
    directed_rows.push_back(mk_row(ACT_START, 32'd0, 1'b0, 1'b0, 4'd15, 1, 1'b1,
                                   STAT_OK, 4'd0, 16'h0000, 64'd0));
    directed_rows.push_back(mk_row(ACT_START, 32'd0, 1'b0, 1'b0, 4'd15, 1, 1'b1,
                                   STAT_OK, 4'd0, 16'h0000, 64'd0));
    directed_rows.push_back(mk_row(ACT_TICK, 32'd0, 1'b0, 1'b0, 4'd0, 1, 1'b1,
                                   STAT_OK, 4'd0, 16'h0001, 64'd1));
    directed_rows.push_back(mk_row(ACT_TICK, 32'd0, 1'b0, 1'b0, 4'd0, 5, 1'b0,
                                   STAT_OK, 4'd0, 16'h0000, 64'd0));
    // Spent one-shot deleted, deleted again, and its slot reused.
    directed_rows.push_back(mk_row(ACT_DELETE, 32'd0, 1'b0, 1'b0, 4'd0, 2, 1'b0,
                                   STAT_OK, 4'd0, 16'h0000, 64'd0));
    directed_rows.push_back(mk_row(ACT_CREATE, 32'd1, 1'b1, 1'b1, 4'd0, 1, 1'b0,
                                   STAT_OK, 4'd0, 16'h0000, 64'd0));
    directed_rows.push_back(mk_row(ACT_TICK, 32'd0, 1'b0, 1'b0, 4'd0, 3, 1'b0,
                                   STAT_OK, 4'd0, 16'h0000, 64'd0));
    directed_rows.push_back(mk_row(ACT_DELETE, 32'd0, 1'b0, 1'b0, 4'd1, 1, 1'b0,
                                   STAT_OK, 4'd0, 16'h0000, 64'd0));
    directed_rows.push_back(mk_row(ACT_START, 32'd0, 1'b0, 1'b0, 4'd1, 1, 1'b0,
                                   STAT_OK, 4'd0, 16'h0000, 64'd0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    foreach (directed_rows[r]) begin
      typed_res.status     = directed_rows[r].st;
      typed_res.slot       = directed_rows[r].slot;
      typed_res.fire_mask  = directed_rows[r].fire;
      typed_res.tick_count = directed_rows[r].count;
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_command(directed_rows[r].act, directed_rows[r].period,
                     directed_rows[r].reload, directed_rows[r].notify,
                     directed_rows[r].sel, directed_rows[r].typed, typed_res);
        burst_gap();
      end
    end
    drain_results();

    // Random part: ticks dominate so timers expire, creates and deletes churn.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) act = ACT_TICK;
      else if (pick < 75) act = ACT_CREATE;
      else if (pick < 92) act = ACT_DELETE;
      else act = ACT_START;
      pick = $urandom_range(0, 99);
      if (pick < 3) per = 32'd0;
      else if (pick < 15) per = $urandom;
      else if (pick < 20) per = 32'hFFFF_FFFF;
      else per = $urandom_range(1, 6);
      send_command(act, per, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   4'($urandom_range(0, 15)), 1'b0, typed_res);
      if (n == RANDOM_ITEMS / 2) drain_results();
      else burst_gap();
    end

    // Let the last results arrive, then allow one full sweep for strays.
    drain_results();
    repeat (NUM_TIMERS + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("software_timer_table_tb: clean");
    end else begin
      $display("software_timer_table_tb: errors");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/stt_pkg.sv
rtl/stt_table.sv
rtl/stt_ctrl.sv
rtl/software_timer_table.sv
test/software_timer_table_tb.sv
